[design/cbd_pkg.sv]
package cbd_pkg;

    localparam int CBD_SIZE_BITS = 32;
    localparam int CBD_BODY_W    = 32;
    localparam int CBD_ERR_W     = 2;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } cbd_item_t;

    typedef struct packed {
        logic [CBD_BODY_W-1:0] body_length;
        logic [CBD_ERR_W-1:0]  error_status;
        logic                  message_done;
        logic                  out_valid;
        logic [7:0]            out_byte;
    } cbd_result_t;

endpackage

[design/cbd_core.sv]
module cbd_core
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = CBD_SIZE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  cbd_item_t             item,
    input  logic [CBD_BODY_W-1:0] max_body_size,
    output cbd_result_t           result
);

    localparam logic [2:0] PH_SIZE      = 3'd0;
    localparam logic [2:0] PH_SIZE_TAIL = 3'd1;
    localparam logic [2:0] PH_SIZE_EXT  = 3'd2;
    localparam logic [2:0] PH_DATA      = 3'd3;
    localparam logic [2:0] PH_DATA_END  = 3'd4;
    localparam logic [2:0] PH_DATA_CR   = 3'd5;
    localparam logic [2:0] PH_TRAILER   = 3'd6;
    localparam logic [2:0] PH_STOP      = 3'd7;

    localparam logic [CBD_ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [CBD_ERR_W-1:0] ERR_FORMAT   = 2'd1;
    localparam logic [CBD_ERR_W-1:0] ERR_TOOLARGE = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int SUM_W = ((SIZE_BITS > CBD_BODY_W) ? SIZE_BITS : CBD_BODY_W) + 1;

    logic [2:0]            phase_reg, phase_next;
    logic [SIZE_BITS-1:0]  chunk_reg, chunk_next;
    logic [CBD_BODY_W-1:0] body_reg, body_next;
    logic [CBD_ERR_W-1:0]  err_reg, err_next;
    logic                  digits_reg, digits_next;
    logic                  bad_reg, bad_next;
    logic [1:0]            tlen_reg, tlen_next;
    logic                  tcr_reg, tcr_next;
    logic                  tcolon_reg, tcolon_next;

    logic [7:0]       c;
    logic             is_lf, is_cr, is_blank;
    logic [4:0]       hex;
    logic [SUM_W-1:0] size_sum;
    logic             too_large;
    logic [2:0]       fin_phase;
    logic [CBD_ERR_W-1:0] fin_err;
    logic             valid;

    // {ok, digit value}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b1, 4'(ch - 8'h30)};
        else if (ch >= 8'h61 && ch <= 8'h66)
            r = {1'b1, 4'(ch - 8'h57)};
        else if (ch >= 8'h41 && ch <= 8'h46)
            r = {1'b1, 4'(ch - 8'h37)};
        return r;
    endfunction

    assign c        = item.in_byte;
    assign is_lf    = (c == CH_LF);
    assign is_cr    = (c == CH_CR);
    assign is_blank = (c == CH_SP) || (c == CH_TAB) || is_cr;
    assign hex      = hex_decode(c);

    // chunk plus body so far against the limit, one wide add and compare
    assign size_sum  = SUM_W'(chunk_reg) + SUM_W'(body_reg);
    assign too_large = (max_body_size != '0) && (size_sum > SUM_W'(max_body_size));

    // outcome of a size line at its line feed
    always_comb
    begin
        fin_phase = PH_DATA;
        fin_err   = err_reg;
        priority if (bad_reg || !digits_reg)
        begin
            fin_phase = PH_STOP;
            fin_err   = ERR_FORMAT;
        end
        else if (chunk_reg == '0)
        begin
            fin_phase = PH_TRAILER;
        end
        else if (too_large)
        begin
            fin_phase = PH_STOP;
            fin_err   = ERR_TOOLARGE;
        end
        else
        begin
            fin_phase = PH_DATA;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        chunk_next  = chunk_reg;
        body_next   = body_reg;
        err_next    = err_reg;
        digits_next = digits_reg;
        bad_next    = bad_reg;
        tlen_next   = tlen_reg;
        tcr_next    = tcr_reg;
        tcolon_next = tcolon_reg;
        valid       = 1'b0;

        if (item.action)
        begin
            phase_next  = PH_SIZE;
            chunk_next  = '0;
            body_next   = '0;
            err_next    = ERR_NONE;
            digits_next = 1'b0;
            bad_next    = 1'b0;
            tlen_next   = 2'd0;
            tcr_next    = 1'b0;
            tcolon_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SIZE, PH_SIZE_TAIL:
                begin
                    if (is_lf)
                    begin
                        phase_next  = fin_phase;
                        err_next    = fin_err;
                        tlen_next   = 2'd0;
                        tcr_next    = 1'b0;
                        tcolon_next = 1'b0;
                    end
                    else if (c == CH_SEMI)
                        phase_next = PH_SIZE_EXT;
                    else if (is_blank)
                    begin
                        if (digits_reg)
                            phase_next = PH_SIZE_TAIL;
                    end
                    else if (!hex[4] || phase_reg == PH_SIZE_TAIL)
                        bad_next = 1'b1;
                    else
                    begin
                        digits_next = 1'b1;
                        if (!bad_reg)
                        begin
                            if (chunk_reg[SIZE_BITS-1 -: 4] != 4'd0)
                                bad_next = 1'b1;
                            else
                                chunk_next = {chunk_reg[SIZE_BITS-5:0], hex[3:0]};
                        end
                    end
                end
                PH_SIZE_EXT:
                begin
                    if (is_lf)
                    begin
                        phase_next  = fin_phase;
                        err_next    = fin_err;
                        tlen_next   = 2'd0;
                        tcr_next    = 1'b0;
                        tcolon_next = 1'b0;
                    end
                end
                PH_DATA:
                begin
                    valid      = 1'b1;
                    chunk_next = chunk_reg - SIZE_BITS'(1);
                    if (body_reg != '1)
                        body_next = body_reg + CBD_BODY_W'(1);
                    if (chunk_reg == SIZE_BITS'(1))
                        phase_next = PH_DATA_END;
                end
                PH_DATA_END, PH_DATA_CR:
                begin
                    if (is_cr && phase_reg == PH_DATA_END)
                        phase_next = PH_DATA_CR;
                    else if (is_lf)
                    begin
                        phase_next  = PH_SIZE;
                        chunk_next  = '0;
                        digits_next = 1'b0;
                        bad_next    = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                        err_next   = ERR_FORMAT;
                    end
                end
                PH_TRAILER:
                begin
                    if (is_lf)
                    begin
                        if (tlen_reg == 2'd0 || (tlen_reg == 2'd1 && tcr_reg))
                            phase_next = PH_STOP;
                        else if (!tcolon_reg)
                        begin
                            phase_next = PH_STOP;
                            err_next   = ERR_FORMAT;
                        end
                        else
                        begin
                            tlen_next   = 2'd0;
                            tcr_next    = 1'b0;
                            tcolon_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (tlen_reg == 2'd0)
                            tcr_next = is_cr;
                        if (tlen_reg != 2'd2)
                            tlen_next = tlen_reg + 2'd1;
                        if (c == CH_COLON)
                            tcolon_next = 1'b1;
                    end
                end
                PH_STOP:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIZE;
            chunk_reg  <= '0;
            body_reg   <= '0;
            err_reg    <= ERR_NONE;
            digits_reg <= 1'b0;
            bad_reg    <= 1'b0;
            tlen_reg   <= 2'd0;
            tcr_reg    <= 1'b0;
            tcolon_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            chunk_reg  <= chunk_next;
            body_reg   <= body_next;
            err_reg    <= err_next;
            digits_reg <= digits_next;
            bad_reg    <= bad_next;
            tlen_reg   <= tlen_next;
            tcr_reg    <= tcr_next;
            tcolon_reg <= tcolon_next;
        end
    end

    always_comb
    begin
        result.out_byte     = valid ? c : 8'd0;
        result.out_valid    = valid;
        result.message_done = (phase_next == PH_STOP) && (err_next == ERR_NONE);
        result.error_status = err_next;
        result.body_length  = body_next;
    end

    // payload only flows while the message is still open
    a_valid_open: assert property (@(posedge clk) disable iff (!rst_n)
        result.out_valid |-> (err_reg == ERR_NONE) && (phase_reg == PH_DATA))
        else $error("payload beat outside chunk data");

    // errors stay until a new message starts
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.action && err_reg != ERR_NONE) |=> (err_reg == $past(err_reg)))
        else $error("error status changed without start");

    // body count never drops inside a message
    a_body_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.action) |=> (body_reg >= $past(body_reg)))
        else $error("body count decreased");

    // data phase always has payload left
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (chunk_reg != '0))
        else $error("data phase with no bytes left");

    // an error always parks the decoder
    a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |-> (phase_reg == PH_STOP))
        else $error("error without stop");

endmodule

[design/chunked_body_decoder.sv]
// channel | dir | handshake          | contents
// s_*     | in  | s_tvalid/s_tready  | tdata: in_byte; tuser: action (start message)
// m_*     | out | m_tvalid/m_tready  | tdata: out_byte, message_done, error_status,
//         |     |                    |        body_length; tuser: out_valid
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: max_body_size
//
// one byte per cycle sustained while the result side is not stalled; an input beat
// goes through the input register, then the decoder state update into the result register
// the state step is a single pass; its longest path is the chunk plus body add
// and compare against the body limit at the size line feed
// rst_n clears the decoder to the start of a size line and the limit to zero
// a stalled result holds; the input register still takes a beat behind it
module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = CBD_SIZE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [8] message_done,
                                   // [10:9] error_status, [42:11] body_length
    output logic        m_tuser,   // [0] out_valid

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // max_body_size
);

    logic                  in_valid_reg;
    cbd_item_t             in_item_reg;
    logic                  out_valid_reg;
    cbd_result_t           out_result_reg;
    cbd_result_t           result;
    logic [CBD_BODY_W-1:0] max_body_reg;
    logic                  advance;
    logic                  step;

    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_body_reg  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (cfg_valid && cfg_ready)
                max_body_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.action  <= s_tuser;
            in_item_reg.in_byte <= s_tdata;
        end
        if (step)
            out_result_reg <= result;
    end

    cbd_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_item_reg),
        .max_body_size(max_body_reg),
        .result       (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.out_valid;
    assign m_tdata  = {5'd0,
                       out_result_reg.body_length,
                       out_result_reg.error_status,
                       out_result_reg.message_done,
                       out_result_reg.out_byte};

endmodule

[dv/cbd_scoreboard.sv]
package cbd_tb_pkg;

    import cbd_pkg::*;

    typedef enum logic [3:0] {
        ST_SIZE,
        ST_SIZE_TAIL,
        ST_SIZE_EXT,
        ST_DATA,
        ST_DATA_END,
        ST_DATA_CR,
        ST_TRAILER,
        ST_STOP
    } dec_state_e;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FORMAT    = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    class body_scoreboard;
        logic [31:0]              body_limit;
        dec_state_e               st;
        logic [CBD_SIZE_BITS-1:0] chunk_left;
        logic [CBD_BODY_W-1:0]    body_total;
        logic [1:0]               err;
        bit                       digits_seen;
        bit                       line_bad;
        logic [1:0]               trl_len;
        bit                       trl_first_cr;
        bit                       trl_colon;
        bit                       msg_done;
        cbd_result_t              expected_q[$];
        int                       n_checked;
        int                       n_fail;

        function new();
            body_limit = '0;
            n_checked  = 0;
            n_fail     = 0;
            clear_message();
        endfunction

        function void clear_size_line();
            chunk_left  = '0;
            digits_seen = 0;
            line_bad    = 0;
        endfunction

        function void clear_trailer_line();
            trl_len      = '0;
            trl_first_cr = 0;
            trl_colon    = 0;
        endfunction

        function void clear_message();
            st         = ST_SIZE;
            body_total = '0;
            err        = ERR_NONE;
            msg_done   = 0;
            clear_size_line();
            clear_trailer_line();
        endfunction

        function void flag_error(logic [1:0] code);
            if (err == ERR_NONE)
                err = code;
            st = ST_STOP;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return -1;
        endfunction

        function void end_size_line();
            logic [63:0] lim;
            lim = {32'd0, body_limit};
            if (line_bad || !digits_seen)
            begin
                flag_error(ERR_FORMAT);
                return;
            end
            if (chunk_left == 0)
            begin
                clear_trailer_line();
                st = ST_TRAILER;
                return;
            end
            if (body_limit != 0 && (64'(chunk_left) > lim ||
                                    64'(body_total) > lim - 64'(chunk_left)))
            begin
                flag_error(ERR_TOO_LARGE);
                return;
            end
            st = ST_DATA;
        endfunction

        function void size_line_byte(logic [7:0] c);
            int d;
            if (c == CH_LF)
            begin
                end_size_line();
                return;
            end
            if (c == CH_SEMI)
            begin
                st = ST_SIZE_EXT;
                return;
            end
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            begin
                if (digits_seen)
                    st = ST_SIZE_TAIL;
                return;
            end
            d = hex_digit(c);
            if (d < 0 || st == ST_SIZE_TAIL)
            begin
                line_bad = 1;
                return;
            end
            digits_seen = 1;
            if (line_bad)
                return;
            // one more digit would push bits past the size width
            if (chunk_left[CBD_SIZE_BITS-1 -: 4] != 0)
            begin
                line_bad = 1;
                return;
            end
            chunk_left = {chunk_left[CBD_SIZE_BITS-5:0], 4'(d)};
        endfunction

        function void note_item(logic action, logic [7:0] c);
            cbd_result_t r;
            bit          payload;
            payload = 0;
            if (action)
                clear_message();
            else
            begin
                case (st)
                    ST_SIZE, ST_SIZE_TAIL:
                        size_line_byte(c);
                    ST_SIZE_EXT:
                        if (c == CH_LF)
                            end_size_line();
                    ST_DATA:
                    begin
                        payload = 1;
                        if (body_total != '1)
                            body_total++;
                        chunk_left--;
                        if (chunk_left == 0)
                            st = ST_DATA_END;
                    end
                    ST_DATA_END:
                        if (c == CH_CR)
                            st = ST_DATA_CR;
                        else if (c == CH_LF)
                        begin
                            clear_size_line();
                            st = ST_SIZE;
                        end
                        else
                            flag_error(ERR_FORMAT);
                    ST_DATA_CR:
                        if (c == CH_LF)
                        begin
                            clear_size_line();
                            st = ST_SIZE;
                        end
                        else
                            flag_error(ERR_FORMAT);
                    ST_TRAILER:
                        if (c == CH_LF)
                        begin
                            if (trl_len == 0 || (trl_len == 1 && trl_first_cr))
                            begin
                                msg_done = 1;
                                st = ST_STOP;
                            end
                            else if (!trl_colon)
                                flag_error(ERR_FORMAT);
                            else
                                clear_trailer_line();
                        end
                        else
                        begin
                            if (trl_len == 0)
                                trl_first_cr = (c == CH_CR);
                            if (trl_len < 2)
                                trl_len++;
                            if (c == CH_COLON)
                                trl_colon = 1;
                        end
                    default:
                        ;
                endcase
            end
            r.out_byte     = payload ? c : 8'd0;
            r.out_valid    = payload;
            r.message_done = msg_done;
            r.error_status = err;
            r.body_length  = body_total;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                n_fail++;
            end
        endfunction

        function void check_result(cbd_result_t got);
            cbd_result_t want;
            n_checked++;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                n_fail++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
            compare_field("message_done", 32'(want.message_done), 32'(got.message_done));
            compare_field("error_status", 32'(want.error_status), 32'(got.error_status));
            compare_field("body_length", 32'(want.body_length), 32'(got.body_length));
        endfunction
    endclass

endpackage

[dv/tb_top.sv]
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cbd_pkg::*;
    import cbd_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int BEATS_PER_PH = 230;
    localparam int NUM_PHASES   = 5;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    body_scoreboard sb;
    int             beats_sent     = 0;
    int             src_idle_pct   = 0;
    int             sink_stall_pct = 0;
    int             cycle_count    = 0;
    logic [7:0]     wire_bytes[$];

    chunked_body_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin : beat_monitor
        cbd_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.body_limit = cfg_data;
            if (m_tvalid && m_tready)
            begin
                got.out_byte     = m_tdata[7:0];
                got.message_done = m_tdata[8];
                got.error_status = m_tdata[10:9];
                got.body_length  = m_tdata[42:11];
                got.out_valid    = m_tuser;
                sb.check_result(got);
            end
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata);
        end
    end

    task automatic put_beat(input logic action, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= action;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_bytes();
        foreach (wire_bytes[i])
            put_beat(1'b0, wire_bytes[i]);
    endtask

    // stop sending and let every expected result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.n_checked < beats_sent)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            wire_bytes.push_back(s[i]);
    endfunction

    function automatic void add_blanks(int n);
        logic [7:0] pick;
        repeat (n)
        begin
            case ($urandom_range(2))
                0: pick = CH_SPACE;
                1: pick = CH_TAB;
                default: pick = CH_CR;
            endcase
            wire_bytes.push_back(pick);
        end
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 10)
            return 8'h30 + 8'(nib);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic void add_size_line(logic [31:0] chunk_len);
        int ndig;
        ndig = 1;
        for (int i = 1; i < 8; i++)
            if ((chunk_len >> (4 * i)) != 0)
                ndig = i + 1;
        if ($urandom_range(3) == 0)
            add_blanks($urandom_range(1, 2));
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) wire_bytes.push_back("0");
        for (int i = ndig - 1; i >= 0; i--)
        begin
            wire_bytes.push_back(hex_char(chunk_len[4*i +: 4]));
            // a blank between digits spoils the line
            if (i != 0 && $urandom_range(49) == 0)
                add_blanks(1);
        end
        if ($urandom_range(3) == 0)
            add_blanks($urandom_range(1, 2));
        if ($urandom_range(4) == 0)
            add_text(";ext=1");
        if ($urandom_range(1))
            wire_bytes.push_back(CH_CR);
        wire_bytes.push_back(CH_LF);
    endfunction

    function automatic void add_line_end();
        if ($urandom_range(1))
            wire_bytes.push_back(CH_CR);
        wire_bytes.push_back(CH_LF);
    endfunction

    function automatic void build_message();
        int          kind;
        int          idx;
        logic [31:0] chunk_len;
        bit          broken;
        kind   = $urandom_range(99);
        broken = 0;
        wire_bytes.delete();
        if (kind < 8)
        begin
            repeat ($urandom_range(3, 20)) wire_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 3))
        begin
            if (!broken)
            begin
                case ($urandom_range(33))
                    0:
                    begin
                        // nine digits, too wide for the size
                        wire_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
                        repeat (8) wire_bytes.push_back(hex_char(4'($urandom_range(15))));
                        add_line_end();
                        broken = 1;
                    end
                    1:
                    begin
                        add_size_line(32'hFFFF_FF00 | 32'($urandom_range(255)));
                        repeat (4) wire_bytes.push_back(8'($urandom_range(255)));
                        broken = 1;
                    end
                    default:
                    begin
                        chunk_len = ($urandom_range(9) == 0) ? $urandom_range(16, 48)
                                                             : $urandom_range(1, 12);
                        add_size_line(chunk_len);
                        repeat (chunk_len) wire_bytes.push_back(8'($urandom_range(255)));
                        add_line_end();
                    end
                endcase
            end
        end
        if (broken)
            return;
        add_size_line(32'd0);
        repeat ($urandom_range(0, 2))
        begin
            repeat ($urandom_range(1, 4)) wire_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            if ($urandom_range(9) != 0)
                wire_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 4)) wire_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            add_line_end();
        end
        add_line_end();
        if (kind < 25)
        begin
            idx = $urandom_range(wire_bytes.size() - 1);
            if ($urandom_range(1))
                wire_bytes[idx] = 8'($urandom_range(255));
            else
                while (wire_bytes.size() > idx)
                    void'(wire_bytes.pop_back());
        end
        else if (kind < 30)
            repeat ($urandom_range(1, 4)) wire_bytes.push_back(8'($urandom_range(255)));
    endfunction

    initial
    begin : main
        logic [31:0] limits[NUM_PHASES];
        int          target;
        sb = new();
        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd24;
        limits[3] = 32'($urandom_range(8, 64));
        limits[4] = 32'd1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: blanks and extension, extreme bytes, trailers, done, too large, bad line
        write_limit(32'd4);
        put_beat(1'b1, 8'hFF);
        wire_bytes.delete();
        add_text("1 ;e\r\n");
        wire_bytes.push_back(8'h00);
        add_text("\r\n0\nt:v\n\r\n");
        send_bytes();
        put_beat(1'b1, 8'h00);
        wire_bytes.delete();
        add_text("5\n");
        send_bytes();
        put_beat(1'b1, 8'h5A);
        wire_bytes.delete();
        add_text("1 2\n");
        send_bytes();
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            write_limit(limits[ph]);
            target = beats_sent + BEATS_PER_PH;
            while (beats_sent < target)
            begin
                put_beat(1'b1, 8'($urandom_range(255)));
                build_message();
                send_bytes();
            end
            drain();
        end

        if (sb.expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.n_fail++;
        end
        if (sb.n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
